### sv/assert_macros.svh
// Assertion helpers for the RTL. Empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AAPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AAPC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define AAPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define AAPC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### sv/aapc_pkg.sv
package aapc_pkg;

    localparam int MAX_PLATFORMS = 16;
    localparam int IDX_W = (MAX_PLATFORMS > 1) ? $clog2(MAX_PLATFORMS) : 1;
    localparam int CNT_W = $clog2(MAX_PLATFORMS + 1);

    localparam logic [1:0] FUNC_STEP  = 2'd0;
    localparam logic [1:0] FUNC_ENTRY = 2'd1;
    localparam logic [1:0] FUNC_PLACE = 2'd2;

    localparam logic [2:0] REG_MOVE_SPEED     = 3'd0;
    localparam logic [2:0] REG_BODY_WIDTH     = 3'd1;
    localparam logic [2:0] REG_BODY_HEIGHT    = 3'd2;
    localparam logic [2:0] REG_PLATFORM_COUNT = 3'd3;
    localparam logic [2:0] REG_BODY_ACTIVE    = 3'd4;

    localparam logic [30:0] Q_ONE = 31'd65536;

    typedef struct packed {
        logic [1:0]         func;
        logic [16:0]        delta_t;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic [3:0]         entry_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [30:0]        entry_width;
        logic [30:0]        entry_height;
        logic               entry_enable;
    } item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               contact_top;
        logic               contact_bottom;
        logic               contact_left;
        logic               contact_right;
    } result_t;

    typedef struct packed {
        logic [30:0] move_speed;
        logic [30:0] body_width;
        logic [30:0] body_height;
        logic [4:0]  platform_count;
        logic        body_active;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        w;
        logic [30:0]        h;
    } plat_t;

    localparam int PLAT_W = $bits(plat_t);

    typedef struct packed {
        logic        hit;
        logic [31:0] pen;
    } axis_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if ((&v[49:31]) || !(|v[49:31]))
            r = v[31:0];
        else if (v[49])
            r = 32'sh8000_0000;
        else
            r = 32'sh7FFF_FFFF;
        return r;
    endfunction

    // Strict overlap on one axis and the half penetration, rounded up.
    function automatic axis_t axis_check(input logic signed [31:0] pos,
                                         input logic signed [31:0] centre,
                                         input logic [30:0] body_size,
                                         input logic [30:0] plat_size);
        logic signed [32:0] d;
        logic [32:0]        ad;
        logic [33:0]        twice;
        logic [31:0]        sum;
        logic [33:0]        diff;
        axis_t              r;
        d     = {pos[31], pos} - {centre[31], centre};
        ad    = d[32] ? 33'(-d) : 33'(d);
        twice = {ad, 1'b0};
        sum   = {1'b0, body_size} + {1'b0, plat_size};
        diff  = {2'b00, sum} - twice + 34'd1;
        r.hit = twice < {2'b00, sum};
        r.pen = diff[32:1];
        return r;
    endfunction

endpackage

### sv/aapc_if.sv
interface aapc_item_if;
    import aapc_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface aapc_result_if;
    import aapc_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface aapc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

### sv/aapc_ram.sv
module aapc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/aapc_step_unit.sv
module aapc_step_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  aapc_pkg::cfg_t cfg_regs,
    aapc_item_if.sink     item,
    aapc_result_if.source result
);
    import aapc_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ACC, S_XLOOP, S_PY_MUL, S_PY_ACC, S_YLOOP, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic [CNT_W-1:0] pi_reg, pi_next, n_reg, n_next;
    logic [MAX_PLATFORMS-1:0] en_reg, en_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [31:0] vx_reg, vx_next, vy_reg, vy_next;
    logic [16:0] dt_reg, dt_next;
    logic signed [31:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [64:0] prod_reg, prod_next;
    logic t_top_reg, t_top_next, t_bot_reg, t_bot_next;
    logic t_left_reg, t_left_next, t_right_reg, t_right_next;
    logic out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    logic signed [31:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [31:0] acc_src;
    logic signed [49:0] acc_sum;
    logic signed [31:0] acc_sat;
    logic [CNT_W-1:0] cnt_lim;
    logic ram_we;
    plat_t ram_wdata, plat;
    axis_t chk_x, chk_y;
    logic plat_hit;
    logic signed [31:0] push_x, push_y;

    aapc_ram #(.WIDTH(PLAT_W), .DEPTH(MAX_PLATFORMS)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(item.data.entry_index)),
        .wdata (ram_wdata),
        .raddr (pi_next[IDX_W-1:0]),
        .rdata (plat)
    );

    assign ram_wdata = '{cx: item.data.coord_x, cy: item.data.coord_y,
                         w: item.data.entry_width, h: item.data.entry_height};
    assign cnt_lim = (int'(cfg_regs.platform_count) > MAX_PLATFORMS)
                   ? CNT_W'(MAX_PLATFORMS) : CNT_W'(cfg_regs.platform_count);

    assign chk_x    = axis_check(px_reg, plat.cx, cfg_regs.body_width, plat.w);
    assign chk_y    = axis_check(py_reg, plat.cy, cfg_regs.body_height, plat.h);
    assign plat_hit = en_reg[pi_reg[IDX_W-1:0]] && chk_x.hit && chk_y.hit;
    assign push_x = sat32((vx_reg > 0)
                  ? ({{18{px_reg[31]}}, px_reg} - {18'd0, chk_x.pen})
                  : ({{18{px_reg[31]}}, px_reg} + {18'd0, chk_x.pen}));
    assign push_y = sat32((vy_reg > 0)
                  ? ({{18{py_reg[31]}}, py_reg} - {18'd0, chk_y.pen})
                  : ({{18{py_reg[31]}}, py_reg} + {18'd0, chk_y.pen}));

    // Shared multiplier operands and accumulator source.
    always_comb
    begin
        mul_a   = vy_reg;
        mul_b   = {16'd0, dt_reg};
        acc_src = py_reg;
        if (state_reg == S_MUL || state_reg == S_ACC)
        begin
            case (op_reg)
                2'd0:
                begin
                    mul_a   = ax_reg;
                    mul_b   = {2'b00, cfg_regs.move_speed};
                    acc_src = '0;
                end
                2'd1:
                begin
                    mul_a   = ax_reg;
                    acc_src = vx_reg;
                end
                2'd2:
                begin
                    mul_a   = ay_reg;
                    acc_src = vy_reg;
                end
                default:
                begin
                    mul_a   = vx_reg;
                    acc_src = px_reg;
                end
            endcase
        end
    end

    assign acc_sum = {{18{acc_src[31]}}, acc_src} + {prod_reg[64], prod_reg[64:16]};
    assign acc_sat = sat32(acc_sum);
    assign item.ready   = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        pi_next = pi_reg;
        n_next = n_reg;
        en_next = en_reg;
        px_next = px_reg;
        py_next = py_reg;
        vx_next = vx_reg;
        vy_next = vy_reg;
        dt_next = dt_reg;
        ax_next = ax_reg;
        ay_next = ay_reg;
        prod_next = prod_reg;
        t_top_next = t_top_reg;
        t_bot_next = t_bot_reg;
        t_left_next = t_left_reg;
        t_right_next = t_right_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        ram_we = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    dt_next = item.data.delta_t;
                    ax_next = item.data.accel_x;
                    ay_next = item.data.accel_y;
                    t_top_next = 1'b0;
                    t_bot_next = 1'b0;
                    t_left_next = 1'b0;
                    t_right_next = 1'b0;
                    op_next = 2'd0;
                    n_next = cnt_lim;
                    state_next = S_DONE;
                    case (item.data.func)
                        FUNC_STEP:
                        begin
                            if (cfg_regs.body_active)
                            begin
                                state_next = S_MUL;
                            end
                        end
                        FUNC_ENTRY:
                        begin
                            if (int'(item.data.entry_index) < MAX_PLATFORMS)
                            begin
                                ram_we = 1'b1;
                                en_next[IDX_W'(item.data.entry_index)] =
                                    item.data.entry_enable;
                            end
                        end
                        FUNC_PLACE:
                        begin
                            px_next = item.data.coord_x;
                            py_next = item.data.coord_y;
                            vx_next = '0;
                            vy_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                prod_next = mul_a * mul_b;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                case (op_reg)
                    2'd0, 2'd1: vx_next = acc_sat;
                    2'd2:       vy_next = acc_sat;
                    default:    px_next = acc_sat;
                endcase
                if (op_reg != 2'd3)
                begin
                    op_next = op_reg + 2'd1;
                    state_next = S_MUL;
                end
                else
                begin
                    pi_next = '0;
                    state_next = (n_reg == '0) ? S_PY_MUL : S_XLOOP;
                end
            end
            S_XLOOP:
            begin
                if (plat_hit && vx_reg != '0)
                begin
                    px_next = push_x;
                    vx_next = '0;
                    t_right_next = t_right_reg || (vx_reg > 0);
                    t_left_next = t_left_reg || (vx_reg < 0);
                end
                pi_next = pi_reg + CNT_W'(1);
                if (pi_next == n_reg)
                begin
                    state_next = S_PY_MUL;
                end
            end
            S_PY_MUL:
            begin
                prod_next = mul_a * mul_b;
                state_next = S_PY_ACC;
            end
            S_PY_ACC:
            begin
                py_next = acc_sat;
                pi_next = '0;
                state_next = (n_reg == '0) ? S_DONE : S_YLOOP;
            end
            S_YLOOP:
            begin
                if (plat_hit && vy_reg != '0)
                begin
                    py_next = push_y;
                    vy_next = '0;
                    t_top_next = t_top_reg || (vy_reg > 0);
                    t_bot_next = t_bot_reg || (vy_reg < 0);
                end
                pi_next = pi_reg + CNT_W'(1);
                if (pi_next == n_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_next = '{pos_x: px_reg, pos_y: py_reg, vel_x: vx_reg,
                                 vel_y: vy_reg, contact_top: t_top_reg,
                                 contact_bottom: t_bot_reg,
                                 contact_left: t_left_reg,
                                 contact_right: t_right_reg};
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= '0;
            pi_reg <= '0;
            n_reg <= '0;
            en_reg <= '0;
            px_reg <= '0;
            py_reg <= '0;
            vx_reg <= '0;
            vy_reg <= '0;
            t_top_reg <= 1'b0;
            t_bot_reg <= 1'b0;
            t_left_reg <= 1'b0;
            t_right_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            pi_reg <= pi_next;
            n_reg <= n_next;
            en_reg <= en_next;
            px_reg <= px_next;
            py_reg <= py_next;
            vx_reg <= vx_next;
            vy_reg <= vy_next;
            t_top_reg <= t_top_next;
            t_bot_reg <= t_bot_next;
            t_left_reg <= t_left_next;
            t_right_reg <= t_right_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg <= dt_next;
        ax_reg <= ax_next;
        ay_reg <= ay_next;
        prod_reg <= prod_next;
        out_reg <= out_next;
    end

    `AAPC_ASSERT_IMP(a_loop_bound, clk, rst_n,
        (state_reg == S_XLOOP || state_reg == S_YLOOP), (pi_reg < n_reg),
        "table walk beyond platform count")
    `AAPC_ASSERT_IMP(a_x_push_stops, clk, rst_n,
        (state_reg == S_YLOOP && (t_left_reg || t_right_reg)), (vx_reg == '0),
        "x push left velocity non-zero")
    `AAPC_ASSERT_NEVER(a_x_flags_excl, clk, rst_n,
        (t_left_reg && t_right_reg), "both horizontal contact flags set")
    `AAPC_ASSERT_NEVER(a_y_flags_excl, clk, rst_n,
        (t_top_reg && t_bot_reg), "both vertical contact flags set")
endmodule

### sv/aabb_platform_collision_step_core.sv
// Moving-box physics step against a table of up to MAX_PLATFORMS platform
// boxes, Q16.16 throughout with saturation to 32 bits. One result per item.
// A step item runs four multiply/accumulate pairs on the single shared
// multiplier, then reads one table entry per cycle from the platform memory
// for the x walk over n entries, n being the platform count clipped to the
// table size, then one more multiply/accumulate pair and the y walk, and
// presents its result through S_DONE and the result register. Entry
// writes, body placement, unused func codes and steps with the body
// inactive go straight from acceptance to S_DONE. The next item can be
// taken in the cycle the result is presented. A new item is taken only
// once the previous one has left the sequencer; the result register lets
// it wait for the sink meanwhile. The table needs no clearing pass: enable
// bits are flops cleared at reset.
module aabb_platform_collision_step_core (
    input  logic      clk,
    input  logic      rst_n,
    aapc_cfg_if.sink  cfg,
    aapc_item_if.sink item,
    aapc_result_if.source result
);
    import aapc_pkg::*;

    cfg_t cfg_reg, cfg_next;

    // Always take configuration transactions; writes land at once.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MOVE_SPEED:     cfg_next.move_speed = cfg.wdata[30:0];
                REG_BODY_WIDTH:     cfg_next.body_width = cfg.wdata[30:0];
                REG_BODY_HEIGHT:    cfg_next.body_height = cfg.wdata[30:0];
                REG_PLATFORM_COUNT: cfg_next.platform_count = cfg.wdata[4:0];
                REG_BODY_ACTIVE:    cfg_next.body_active = cfg.wdata[0];
                default:
                begin
                    // drop writes to unmapped indices
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{move_speed: Q_ONE, body_width: Q_ONE, body_height: Q_ONE,
                         platform_count: 5'd0, body_active: 1'b1};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer, platform memory and body state.
    aapc_step_unit u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_reg),
        .item     (item),
        .result   (result)
    );
endmodule

### dv/aabb_platform_collision_step_core_tb.sv
module aabb_platform_collision_step_core_tb;
    import aapc_pkg::*;

    logic clk;
    logic rst_n;

    aapc_cfg_if    cfg_ch();
    aapc_item_if   itm();
    aapc_result_if res();

    aabb_platform_collision_step_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (itm),
        .result (res)
    );

    // Shadow copy of the register file, as the block should hold it.
    longint speed_q, width_q, height_q;
    int     count_q;
    bit     active_q;

    // Shadow copy of the body and the platform table.
    longint pos_x_q, pos_y_q, vel_x_q, vel_y_q;
    longint plat_cx [MAX_PLATFORMS];
    longint plat_cy [MAX_PLATFORMS];
    longint plat_w  [MAX_PLATFORMS];
    longint plat_h  [MAX_PLATFORMS];
    bit     plat_en [MAX_PLATFORMS];

    item_t   pending_items[$];
    result_t expected_state_q[$];
    bit      item_fire;
    bit      calm;
    int      fail_count;

    always #5 clk = ~clk;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 product, floored.
    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit hits(int i);
        return (2 * mag(pos_x_q - plat_cx[i]) < width_q + plat_w[i]) &&
               (2 * mag(pos_y_q - plat_cy[i]) < height_q + plat_h[i]);
    endfunction

    // Advance the shadow body by one transaction and return what it reports.
    function automatic result_t advance_body(item_t it);
        longint  dt, ax, ay, pen;
        int      n;
        result_t r;
        r  = '0;
        dt = longint'({1'b0, it.delta_t});
        ax = longint'(it.accel_x);
        ay = longint'(it.accel_y);
        if (it.func == FUNC_STEP && active_q) begin
            n = (count_q > MAX_PLATFORMS) ? MAX_PLATFORMS : count_q;
            vel_x_q = clamp32(qmul(ax, speed_q));
            vel_x_q = clamp32(vel_x_q + qmul(ax, dt));
            vel_y_q = clamp32(vel_y_q + qmul(ay, dt));
            pos_x_q = clamp32(pos_x_q + qmul(vel_x_q, dt));
            for (int i = 0; i < n; i++) begin
                if (plat_en[i] && hits(i)) begin
                    pen = (width_q + plat_w[i] - 2 * mag(pos_x_q - plat_cx[i]) + 1) >>> 1;
                    if (vel_x_q > 0) begin
                        pos_x_q = clamp32(pos_x_q - pen);
                        vel_x_q = 0;
                        r.contact_right = 1'b1;
                    end
                    else if (vel_x_q < 0) begin
                        pos_x_q = clamp32(pos_x_q + pen);
                        vel_x_q = 0;
                        r.contact_left = 1'b1;
                    end
                end
            end
            pos_y_q = clamp32(pos_y_q + qmul(vel_y_q, dt));
            for (int i = 0; i < n; i++) begin
                if (plat_en[i] && hits(i)) begin
                    pen = (height_q + plat_h[i] - 2 * mag(pos_y_q - plat_cy[i]) + 1) >>> 1;
                    if (vel_y_q > 0) begin
                        pos_y_q = clamp32(pos_y_q - pen);
                        vel_y_q = 0;
                        r.contact_top = 1'b1;
                    end
                    else if (vel_y_q < 0) begin
                        pos_y_q = clamp32(pos_y_q + pen);
                        vel_y_q = 0;
                        r.contact_bottom = 1'b1;
                    end
                end
            end
        end
        else if (it.func == FUNC_ENTRY) begin
            plat_cx[it.entry_index] = longint'(it.coord_x);
            plat_cy[it.entry_index] = longint'(it.coord_y);
            plat_w[it.entry_index]  = longint'({1'b0, it.entry_width});
            plat_h[it.entry_index]  = longint'({1'b0, it.entry_height});
            plat_en[it.entry_index] = it.entry_enable;
        end
        else if (it.func == FUNC_PLACE) begin
            pos_x_q = longint'(it.coord_x);
            pos_y_q = longint'(it.coord_y);
            vel_x_q = 0;
            vel_y_q = 0;
        end
        r.pos_x = pos_x_q[31:0];
        r.pos_y = pos_y_q[31:0];
        r.vel_x = vel_x_q[31:0];
        r.vel_y = vel_y_q[31:0];
        return r;
    endfunction

    function automatic bit stall_now();
        return !calm && ($urandom_range(99) < 23);
    endfunction

    function automatic item_t make_item(logic [1:0] f, logic [16:0] dt,
                                        logic signed [31:0] ax, logic signed [31:0] ay,
                                        logic [3:0] idx, logic signed [31:0] cx,
                                        logic signed [31:0] cy, logic [30:0] w,
                                        logic [30:0] h, logic en);
        item_t it;
        it.func = f;
        it.delta_t = dt;
        it.accel_x = ax;
        it.accel_y = ay;
        it.entry_index = idx;
        it.coord_x = cx;
        it.coord_y = cy;
        it.entry_width = w;
        it.entry_height = h;
        it.entry_enable = en;
        return it;
    endfunction

    function automatic logic signed [31:0] near_coord();
        return $signed($urandom_range(524288)) - 32'sd262144;
    endfunction

    // Mostly steps around a cluster of platforms, with entry rewrites,
    // placements and a share of raw noise across every field.
    function automatic item_t random_item();
        item_t it;
        int    pick;
        it   = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 8) begin
            if (it.func == FUNC_STEP && $urandom_range(1))
                it.delta_t = it.delta_t % 17'd65537;
        end
        else if (pick < 22) begin
            it.func = FUNC_ENTRY;
            it.coord_x = near_coord();
            it.coord_y = near_coord();
            it.entry_width = 31'($urandom_range(262144));
            it.entry_height = 31'($urandom_range(262144));
            it.entry_enable = ($urandom_range(9) < 8);
        end
        else if (pick < 30) begin
            it.func = FUNC_PLACE;
            it.coord_x = near_coord();
            it.coord_y = near_coord();
        end
        else begin
            it.func = FUNC_STEP;
            it.delta_t = 17'($urandom_range(65536));
            it.accel_x = $signed($urandom_range(262144)) - 32'sd131072;
            it.accel_y = $signed($urandom_range(262144)) - 32'sd131072;
        end
        return it;
    endfunction

    // Hold the write until the register port takes it, then mirror it.
    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_MOVE_SPEED:     speed_q  = longint'({1'b0, v[30:0]});
            REG_BODY_WIDTH:     width_q  = longint'({1'b0, v[30:0]});
            REG_BODY_HEIGHT:    height_q = longint'({1'b0, v[30:0]});
            REG_PLATFORM_COUNT: count_q  = int'(v[4:0]);
            REG_BODY_ACTIVE:    active_q = v[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_all(logic [31:0] sp, logic [31:0] bw, logic [31:0] bh,
                             logic [31:0] cnt, logic [31:0] act);
        write_reg(REG_MOVE_SPEED, sp);
        write_reg(REG_BODY_WIDTH, bw);
        write_reg(REG_BODY_HEIGHT, bh);
        write_reg(REG_PLATFORM_COUNT, cnt);
        write_reg(REG_BODY_ACTIVE, act);
    endtask

    // Wait for every queued transaction to come back, then let the block settle.
    task automatic drain();
        while (pending_items.size() != 0 || itm.valid || expected_state_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_phase(int n);
        repeat (n) pending_items.push_back(random_item());
        drain();
    endtask

    // Item driver: present the next transaction at the falling edge.
    always @(negedge clk) begin
        if (rst_n && (!itm.valid || item_fire)) begin
            if (pending_items.size() != 0 && !stall_now()) begin
                itm.data  <= pending_items.pop_front();
                itm.valid <= 1'b1;
            end
            else begin
                itm.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n)
            res.ready <= !stall_now();
    end

    // Monitor: predict on acceptance, check results in order.
    always @(posedge clk) begin
        result_t got, want;
        item_fire <= itm.valid && itm.ready;
        if (rst_n && itm.valid && itm.ready)
            expected_state_q.push_back(advance_body(itm.data));
        if (rst_n && res.valid && res.ready) begin
            got = res.data;
            if (expected_state_q.size() == 0) begin
                $error("result with nothing expected: %h", got);
                fail_count++;
            end
            else begin
                want = expected_state_q.pop_front();
                if (got.pos_x !== want.pos_x) begin
                    $error("pos_x expected %0d actual %0d", want.pos_x, got.pos_x);
                    fail_count++;
                end
                if (got.pos_y !== want.pos_y) begin
                    $error("pos_y expected %0d actual %0d", want.pos_y, got.pos_y);
                    fail_count++;
                end
                if (got.vel_x !== want.vel_x) begin
                    $error("vel_x expected %0d actual %0d", want.vel_x, got.vel_x);
                    fail_count++;
                end
                if (got.vel_y !== want.vel_y) begin
                    $error("vel_y expected %0d actual %0d", want.vel_y, got.vel_y);
                    fail_count++;
                end
                if (got.contact_top !== want.contact_top) begin
                    $error("contact_top expected %0b actual %0b",
                           want.contact_top, got.contact_top);
                    fail_count++;
                end
                if (got.contact_bottom !== want.contact_bottom) begin
                    $error("contact_bottom expected %0b actual %0b",
                           want.contact_bottom, got.contact_bottom);
                    fail_count++;
                end
                if (got.contact_left !== want.contact_left) begin
                    $error("contact_left expected %0b actual %0b",
                           want.contact_left, got.contact_left);
                    fail_count++;
                end
                if (got.contact_right !== want.contact_right) begin
                    $error("contact_right expected %0b actual %0b",
                           want.contact_right, got.contact_right);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.wdata = '0;
        itm.valid = 1'b0;
        itm.data = '0;
        res.ready = 1'b0;
        item_fire = 1'b0;
        calm = 1'b0;
        fail_count = 0;
        speed_q = Q_ONE;
        width_q = Q_ONE;
        height_q = Q_ONE;
        count_q = 0;
        active_q = 1'b1;
        pos_x_q = 0;
        pos_y_q = 0;
        vel_x_q = 0;
        vel_y_q = 0;
        for (int i = 0; i < MAX_PLATFORMS; i++) begin
            plat_cx[i] = 0;
            plat_cy[i] = 0;
            plat_w[i]  = 0;
            plat_h[i]  = 0;
            plat_en[i] = 1'b0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset defaults: a step with an empty table, then set the platform count to the full table.
        pending_items.push_back(make_item(FUNC_STEP, 17'd65536, 32'sd65536, -32'sd65536,
                                          4'd0, 0, 0, 0, 0, 1'b0));
        drain();
        write_reg(REG_PLATFORM_COUNT, 32'd16);

        // Directed: extremes, unused func code, approaches from four sides (only right
        // and top push), an overlap at rest, and an entry that is switched off.
        pending_items.push_back(make_item(FUNC_PLACE, 0, 0, 0, 4'd15, 0, 0, 0, 0, 1'b1));
        pending_items.push_back(make_item(FUNC_ENTRY, 0, 0, 0, 4'd0, 32'sd131072, 0,
                                          31'd65536, 31'd65536, 1'b1));
        pending_items.push_back(make_item(FUNC_STEP, 17'd65536, 32'sd65536, 0, 0, 0, 0,
                                          0, 0, 1'b0));
        pending_items.push_back(make_item(FUNC_PLACE, 0, 0, 0, 0, 32'sd196608, 0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_STEP, 17'd65536, -32'sd65536, 0, 0, 0, 0,
                                          0, 0, 1'b0));
        pending_items.push_back(make_item(FUNC_ENTRY, 0, 0, 0, 4'd1, 0, -32'sd131072,
                                          31'd65536, 31'd65536, 1'b1));
        pending_items.push_back(make_item(FUNC_PLACE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_STEP, 17'd65536, 0, -32'sd65536, 0, 0, 0,
                                          0, 0, 1'b0));
        pending_items.push_back(make_item(FUNC_PLACE, 0, 0, 0, 0, 0, -32'sd196608, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_STEP, 17'd65536, 0, 32'sd65536, 0, 0, 0,
                                          0, 0, 1'b0));
        pending_items.push_back(make_item(FUNC_PLACE, 0, 0, 0, 0, 32'sd131072, 0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_STEP, 17'd0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        pending_items.push_back(make_item(FUNC_ENTRY, 0, 0, 0, 4'd0, 32'sd131072, 0,
                                          31'd65536, 31'd65536, 1'b0));
        pending_items.push_back(make_item(FUNC_STEP, 17'd65536, 32'sd65536, 0, 0, 0, 0,
                                          0, 0, 1'b0));
        pending_items.push_back(make_item(2'd3, 17'h1FFFF, 32'h7FFFFFFF, 32'h80000000,
                                          4'd15, 32'h7FFFFFFF, 32'h80000000,
                                          31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1));
        pending_items.push_back(make_item(FUNC_STEP, 17'd65536, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                          0, 0, 0, 0, 0, 1'b0));
        pending_items.push_back(make_item(FUNC_STEP, 17'd65536, 32'h80000000, 32'h80000000,
                                          0, 0, 0, 0, 0, 1'b0));
        pending_items.push_back(make_item(FUNC_PLACE, 0, 0, 0, 0, 32'h7FFFFFFF,
                                          32'h80000000, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_ENTRY, 0, 0, 0, 4'd15, 32'h80000000,
                                          32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1));
        pending_items.push_back(make_item(FUNC_STEP, 17'd65536, 32'h7FFFFFFF, 32'h80000000,
                                          0, 0, 0, 0, 0, 1'b0));
        drain();

        // Random phases across register settings, extremes included.
        write_all(32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 32'd16, 32'd1);
        random_phase(250);
        calm = 1'b1;
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(200);
        calm = 1'b0;
        write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h8000_0001);
        random_phase(200);
        write_all($urandom_range(262144), $urandom_range(262144), $urandom_range(262144),
                  $urandom_range(20), 32'd1);
        random_phase(300);
        write_all($urandom, $urandom, $urandom, 32'd8, 32'hFFFF_FFFE);
        random_phase(200);
        write_all(32'h0000_8000, 32'h0001_8000, 32'h0000_8000, 32'd17, 32'd1);
        random_phase(300);
        write_all(32'h0001_0000, 32'h0001_0000, 32'h0003_0000, $urandom_range(16), 32'd1);
        random_phase(300);

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

### files.f
+incdir+sv
sv/aapc_pkg.sv
sv/aapc_if.sv
sv/aapc_ram.sv
sv/aapc_step_unit.sv
sv/aabb_platform_collision_step_core.sv
dv/aabb_platform_collision_step_core_tb.sv
